// ===== src/sliding_median_goal_filter_assert.svh =====
// Assertion macros shared by the checker of the sliding median goal filter.
// Needs a clock named clk and an active low reset named arst_n in scope.
`ifndef SLIDING_MEDIAN_GOAL_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_GOAL_FILTER_ASSERT_SVH

// Checked only outside reset.
`define SMGF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMGF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/smgf_pkg.sv =====
// Package of the sliding median goal filter: sizes, codes, types and the
// saturating adder. Used by the top, the sorter and the checker; depends on nothing.
package smgf_pkg;

	localparam int WINDOW = 10;
	localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int RAM_W = 64;

	localparam int S_TUSER_W = 2;
	localparam int S_TDATA_W = 136;
	localparam int M_TUSER_W = 1;
	localparam int M_TDATA_W = 104;
	localparam int M_PAD_W = M_TDATA_W - 97;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 1'd1;

	localparam logic signed [31:0] OFFSET_X_RESET = -32'sd58982;
	localparam logic signed [31:0] OFFSET_Y_RESET = 32'sd3277;

	localparam logic [M_TUSER_W-1:0] KIND_GOAL = 1'b0;
	localparam logic [M_TUSER_W-1:0] KIND_REPORT = 1'b1;

	typedef enum logic [1:0] {
		OP_DETECT  = 2'd0,
		OP_COLLECT = 2'd1,
		OP_OTHER   = 2'd2,
		OP_REACHED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic push;
	} sort_ctl_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

endpackage

// ===== src/sliding_median_goal_filter.sv =====
// Sliding median goal filter, top level. Detections, other actions, ignored reports and
// collects without a goal leave the block idle; a report goes through the emit state, its
// beat registered as the result and then as the output. A collect with a goal reads every
// filled entry before offering its beat, as the one read port of the window RAM feeds the
// insertion sorters one entry a cycle; a stalled output beat holds the next result and the
// input off. Reset is asynchronous, active low; the window RAM needs no clearing pass.
module sliding_median_goal_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// op
	input  logic [smgf_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	// point_x, point_y, point_z, request_id, reached, zero padding
	input  logic [smgf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// kind
	output logic [smgf_pkg::M_TUSER_W-1:0]      m_axis_tuser,
	// goal_x, goal_y, report_id, success, zero padding
	output logic [smgf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [smgf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smgf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import smgf_pkg::*;

	state_t state_q, state_d;

	logic signed [31:0] off_x_q, off_y_q;
	logic [ADDR_W-1:0] wslot_q;
	logic [CNT_W-1:0] fill_q, rd_idx_q;
	logic last_zero_q, collecting_q, pend_valid_q;
	logic [31:0] pend_id_q;
	logic rvalid_q;

	logic [M_TUSER_W-1:0] res_kind_q;
	logic [M_TDATA_W-1:0] res_data_q;
	logic [M_TUSER_W-1:0] m_tuser_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic m_tvalid_q;

	logic accept;
	op_t in_op;
	logic signed [31:0] in_px, in_py, in_pz;
	logic [31:0] in_rid;
	logic in_reached;
	logic start_sort, start_rep, sort_done, emit_go;

	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [RAM_W-1:0] rd_data;
	sort_ctl_t sort_ctl;
	logic [ADDR_W-1:0] med_idx;
	logic signed [31:0] med_x, med_y;
	logic signed [31:0] goal_x, goal_y;

	assign in_op = op_t'(s_axis_tuser);
	assign in_px = s_axis_tdata[31:0];
	assign in_py = s_axis_tdata[63:32];
	assign in_pz = s_axis_tdata[95:64];
	assign in_rid = s_axis_tdata[127:96];
	assign in_reached = s_axis_tdata[128];

	assign accept = s_axis_tvalid && s_axis_tready;
	assign start_sort = accept && (in_op == OP_COLLECT) && (fill_q != '0) && !last_zero_q;
	assign start_rep = accept && (in_op == OP_REACHED) && collecting_q;
	assign sort_done = (state_q == ST_SORT) && !rvalid_q && !(rd_idx_q < fill_q);
	assign emit_go = (state_q == ST_EMIT) && (!m_tvalid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_sort) begin
					state_d = ST_SORT;
				end else if (start_rep) begin
					state_d = ST_EMIT;
				end
			end
			ST_SORT: begin
				if (sort_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		sort_ctl = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				rd_en = start_sort;
				sort_ctl.clear = start_sort;
			end
			ST_SORT: begin
				rd_en = rd_idx_q < fill_q;
				rd_addr = rd_idx_q[ADDR_W-1:0];
				sort_ctl.push = rvalid_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= OFFSET_X_RESET;
			off_y_q <= OFFSET_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X: off_x_q <= cfg_wdata;
				REG_OFFSET_Y: off_y_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Window bookkeeping and the collect and report flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			fill_q <= '0;
			last_zero_q <= 1'b1;
			collecting_q <= 1'b0;
			pend_id_q <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			case (in_op)
				OP_DETECT: begin
					wslot_q <= (wslot_q == ADDR_W'(WINDOW - 1)) ? '0 : wslot_q + ADDR_W'(1);
					if (fill_q < CNT_W'(WINDOW)) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					last_zero_q <= (in_px == '0) && (in_py == '0) && (in_pz == '0);
				end
				OP_COLLECT: begin
					pend_id_q <= in_rid;
					pend_valid_q <= 1'b1;
					collecting_q <= 1'b1;
				end
				OP_OTHER: begin
					collecting_q <= 1'b0;
				end
				OP_REACHED: begin
					if (in_reached) begin
						collecting_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Read sequencing: rvalid_q marks a beat of RAM data arriving this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= rd_en;
			if (start_sort) begin
				rd_idx_q <= CNT_W'(1);
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	smgf_ram #(
		.DEPTH(WINDOW),
		.WIDTH(RAM_W),
		.AW(ADDR_W)
	) u_window (
		.clk(clk),
		.we(accept && (in_op == OP_DETECT)),
		.waddr(wslot_q),
		.wdata({in_py, in_px}),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign med_idx = ADDR_W'(fill_q >> 1);

	smgf_sorter u_sort_x (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sort_ctl),
		.din(rd_data[31:0]),
		.sel(med_idx),
		.dout(med_x)
	);

	smgf_sorter u_sort_y (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sort_ctl),
		.din(rd_data[63:32]),
		.sel(med_idx),
		.dout(med_y)
	);

	assign goal_x = sat_add(med_x, off_x_q);
	assign goal_y = sat_add(med_y, off_y_q);

	always_ff @(posedge clk) begin
		if (sort_done) begin
			res_kind_q <= KIND_GOAL;
			res_data_q <= {{M_PAD_W{1'b0}}, 1'b0, 32'd0, goal_y, goal_x};
		end else if (start_rep) begin
			res_kind_q <= KIND_REPORT;
			res_data_q <= {{M_PAD_W{1'b0}}, in_reached,
				(pend_valid_q ? pend_id_q : 32'd0), 64'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_tuser_q <= res_kind_q;
			m_tdata_q <= res_data_q;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tuser = m_tuser_q;
	assign m_axis_tdata = m_tdata_q;

endmodule

// ===== src/smgf_ram.sv =====
// Simple dual port RAM with one write port and a registered read port.
// Generic; holds the point window of the filter.
module smgf_ram #(
	parameter int DEPTH = 10,
	parameter int WIDTH = 64,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/smgf_sorter.sv =====
// Insertion sorter: takes one value a beat and keeps the values seen since
// the last clear in ascending order. Depends on smgf_pkg.
module smgf_sorter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  smgf_pkg::sort_ctl_t       ctl,
	input  logic signed [31:0]        din,
	input  logic [smgf_pkg::ADDR_W-1:0] sel,
	output logic signed [31:0]        dout
);
	import smgf_pkg::*;

	logic signed [31:0] lanes_q [WINDOW];
	logic signed [31:0] lanes_d [WINDOW];
	logic [WINDOW-1:0] le;
	logic [CNT_W-1:0] cnt_q;

	// The lanes below the count form a sorted prefix, so le is a run of ones
	// followed by zeros: the new value lands at the first zero.
	for (genvar p = 0; p < WINDOW; p++) begin : g_lane
		assign le[p] = (CNT_W'(p) < cnt_q) && (lanes_q[p] <= din);
		if (p == 0) begin : g_first
			assign lanes_d[p] = le[p] ? lanes_q[p] : din;
		end else begin : g_rest
			assign lanes_d[p] = le[p] ? lanes_q[p] :
				(le[p-1] ? din : lanes_q[p-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			for (int i = 0; i < WINDOW; i++) begin
				lanes_q[i] <= lanes_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign dout = lanes_q[sel];

endmodule

// ===== src/smgf_checker.sv =====
// Port level checker for the sliding median goal filter, bound to the top.
// Depends on smgf_pkg and the assertion macro header.
`include "sliding_median_goal_filter_assert.svh"

module smgf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [smgf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [smgf_pkg::M_TUSER_W-1:0]  m_axis_tuser,
	input logic [smgf_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import smgf_pkg::*;

	`SMGF_ASSERT_ALWAYS(a_no_beat_in_reset, !arst_n |-> !m_axis_tvalid, "result offered during reset")

	`SMGF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	`SMGF_ASSERT(a_goal_fields, m_axis_tvalid && (m_axis_tuser == KIND_GOAL) |-> (m_axis_tdata[96:64] == '0), "goal beat carries report fields")

	`SMGF_ASSERT(a_report_fields, m_axis_tvalid && (m_axis_tuser == KIND_REPORT) |-> (m_axis_tdata[63:0] == '0), "report beat carries goal fields")

	// Detections and other actions finish in the cycle they are taken.
	`SMGF_ASSERT(a_quick_ops, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_DETECT || s_axis_tuser == OP_OTHER) |=> s_axis_tready, "block busy after a single cycle item")

endmodule

bind sliding_median_goal_filter smgf_checker u_checker (.*);
